FILE: rtl/uks_pkg.sv
`default_nettype none

package uks_pkg;

  // command opcodes; the unused code behaves as a query
  localparam logic [1:0] OP_QUERY  = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_MISS = 2'd3;

  localparam int OPCODE_W = 2;
  localparam int KEY_W    = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 4;

  // strobes broadcast from the sequencer to every cell
  typedef struct packed {
    logic cmp;
    logic add;
    logic del;
  } uks_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/unique_key_set_store.sv
`default_nettype none

// Bounded set of up to CAPACITY unique keys, kept in insertion order in a row
// of cells, one key per cell. Each command beat (opcode on s_tuser, key on
// s_tdata) queries, adds or removes a key and returns one result beat with
// success, status and the entry count after the command. A command goes
// through accept, a parallel compare in every cell, then execute, where
// a remove shifts every later cell down by one from its upper neighbor and an
// add loads the cell just past the last entry. One command is in flight at a
// time, so the block takes no new beat until the last command has left
// execute. The result register holds while m_tready is low and the next
// command waits in execute until that register is free.

module unique_key_set_store
  import uks_pkg::*;
#(
  parameter int CAPACITY = 10,
  parameter int KEY_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output      logic                s_tready,
  input  wire logic [KEY_W-1:0]    s_tdata,   // [15:0] key
  input  wire logic [OPCODE_W-1:0] s_tuser,   // [1:0] opcode
  output      logic                m_tvalid,
  input  wire logic                m_tready,
  output      logic [7:0]          m_tdata,   // [3:0] entry_count, [7:4] zero
  output      logic [2:0]          m_tuser    // [0] success, [2:1] status
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [1:0]          op;
  logic [KEY_BITS-1:0] key_q;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;

  logic [KEY_BITS-1:0] entries [CAPACITY];
  logic [CAPACITY-1:0] match_vec;
  logic [CAPACITY:0]   hit;

  uks_ctl_t            ctl;
  logic                go;
  logic                found;
  logic                full;
  logic                ok;
  logic [1:0]          st;

  assign s_tready = (state == S_IDLE);
  assign go       = !m_tvalid || m_tready;
  assign found    = hit[CAPACITY];
  assign full     = (count == CNT_W'(CAPACITY));
  assign hit[0]   = 1'b0;

  always_comb begin
    ok         = 1'b0;
    st         = ST_OK;
    count_next = count;
    ctl.cmp    = (state == S_CMP);
    ctl.add    = 1'b0;
    ctl.del    = 1'b0;
    case (op)
      OP_ADD: begin
        if (found) begin
          st = ST_DUP;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          ok         = 1'b1;
          count_next = count + CNT_W'(1);
          ctl.add    = (state == S_EXEC) && go;
        end
      end
      OP_REMOVE: begin
        if (found) begin
          ok         = 1'b1;
          count_next = count - CNT_W'(1);
          ctl.del    = (state == S_EXEC) && go;
        end else begin
          st = ST_MISS;
        end
      end
      default: begin
        if (found) begin
          ok = 1'b1;
        end else begin
          st = ST_MISS;
        end
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (go) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EXEC && go) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op    <= s_tuser;
      key_q <= KEY_BITS'(s_tdata);
    end
    if (state == S_EXEC && go) begin
      m_tuser <= {st, ok};
      m_tdata <= {4'b0000, COUNT_W'(count_next)};
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_BITS-1:0] nbr;
    if (i == CAPACITY - 1) begin : g_top
      assign nbr = key_q;
    end else begin : g_mid
      assign nbr = entries[i+1];
    end

    uks_cell #(
      .KEY_BITS (KEY_BITS),
      .CNT_W    (CNT_W),
      .INDEX    (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .key       (key_q),
      .count     (count),
      .nbr_entry (nbr),
      .hit_in    (hit[i]),
      .entry     (entries[i]),
      .match     (match_vec[i]),
      .hit_out   (hit[i+1])
    );
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_unique_keys: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |-> $onehot0(match_vec))
    else $error("key stored in more than one cell");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.add |=> count == $past(count) + CNT_W'(1))
    else $error("add did not grow the count");

  a_del_shrinks: assert property (@(posedge clk) disable iff (rst)
    ctl.del |=> count == $past(count) - CNT_W'(1))
    else $error("remove did not shrink the count");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == S_CMP && !s_tready)
    else $error("beat accepted while a command is in flight");

endmodule

`default_nettype wire

FILE: rtl/uks_cell.sv
`default_nettype none

module uks_cell
  import uks_pkg::*;
#(
  parameter int KEY_BITS = 16,
  parameter int CNT_W    = 4,
  parameter int INDEX    = 0
) (
  input  wire logic                clk,
  input  wire uks_ctl_t            ctl,
  input  wire logic [KEY_BITS-1:0] key,
  input  wire logic [CNT_W-1:0]    count,
  input  wire logic [KEY_BITS-1:0] nbr_entry,
  input  wire logic                hit_in,
  output      logic [KEY_BITS-1:0] entry,
  output      logic                match,
  output      logic                hit_out
);

  logic active;
  logic is_tail;

  assign active  = count > CNT_W'(INDEX);
  assign is_tail = count == CNT_W'(INDEX);
  assign hit_out = hit_in | match;

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      match <= active && (entry == key);
    end
    if (ctl.add && is_tail) begin
      entry <= key;
    end else if (ctl.del && hit_out) begin
      // close the gap: take the upper neighbor's key
      entry <= nbr_entry;
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import uks_pkg::*;

  localparam int CAPACITY = 10;
  localparam int KEY_BITS = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 150;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic                success;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } set_result_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [KEY_W-1:0]    s_tdata = '0;
  logic [OPCODE_W-1:0] s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [7:0]          m_tdata;
  logic [2:0]          m_tuser;

  // shadow copy of the key set
  logic [KEY_W-1:0] key_table [CAPACITY];
  int               key_total = 0;
  set_result_t      result_q[$];

  int err_cnt = 0;
  int cycle_cnt = 0;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  unique_key_set_store #(
    .CAPACITY(CAPACITY),
    .KEY_BITS(KEY_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),   // [15:0] key
    .s_tuser(s_tuser),   // [1:0] opcode
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),   // [3:0] entry_count, [7:4] zero
    .m_tuser(m_tuser)    // [0] success, [2:1] status
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // apply one command to the shadow set and return its result
  function automatic set_result_t apply_cmd(logic [1:0] op, logic [KEY_W-1:0] key);
    set_result_t r;
    int slot;
    int i;
    slot = -1;
    for (i = 0; i < key_total; i++) begin
      if (slot < 0 && key_table[i] == key) slot = i;
    end
    r.success = 1'b0;
    r.status = ST_OK;
    if (op == OP_ADD) begin
      if (slot >= 0) begin
        r.status = ST_DUP;
      end else if (key_total >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        key_table[key_total] = key;
        key_total++;
        r.success = 1'b1;
      end
    end else if (op == OP_REMOVE) begin
      if (slot >= 0) begin
        for (i = slot; i + 1 < key_total; i++) key_table[i] = key_table[i + 1];
        key_total--;
        r.success = 1'b1;
      end else begin
        r.status = ST_MISS;
      end
    end else begin
      // query, and the unused opcode acting as one
      if (slot >= 0) r.success = 1'b1;
      else r.status = ST_MISS;
    end
    r.count = key_total[COUNT_W-1:0];
    return r;
  endfunction

  task automatic send_cmd(logic [1:0] op, logic [KEY_W-1:0] key);
    int gap;
    gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= key;
    s_tuser <= op;
    do @(posedge clk); while (!s_tready);
    result_q.push_back(apply_cmd(op, key));
  endtask

  task automatic drop_valid();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drain();
    drop_valid();
    while (result_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    set_result_t want;
    set_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.success = m_tuser[0];
      got.status = m_tuser[2:1];
      got.count = m_tdata[3:0];
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result beat tuser=%h tdata=%h", $time, m_tuser, m_tdata);
        err_cnt++;
      end else begin
        want = result_q.pop_front();
        if (got.success !== want.success) begin
          $display("%0t: success exp %b got %b", $time, want.success, got.success);
          err_cnt++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          err_cnt++;
        end
        if (got.count !== want.count) begin
          $display("%0t: entry_count exp %0d got %0d", $time, want.count, got.count);
          err_cnt++;
        end
        if (m_tdata[7:4] !== 4'd0) begin
          $display("%0t: tdata pad exp 0 got %h", $time, m_tdata[7:4]);
          err_cnt++;
        end
      end
    end
  end

  // edge keys, every opcode, duplicate, full table and removal positions
  task automatic test_directed();
    int i;
    sender_idle_pct = 0;
    stall_pct = 0;
    send_cmd(OP_QUERY, 16'h0000);
    send_cmd(OP_REMOVE, 16'h1234);
    send_cmd(OP_ADD, 16'h0000);
    send_cmd(OP_ADD, 16'hFFFF);
    send_cmd(OP_ADD, 16'h0000);
    send_cmd(OP_QUERY, 16'hFFFF);
    send_cmd(OP_UNUSED, 16'hFFFF);
    send_cmd(OP_UNUSED, 16'h5555);
    send_cmd(OP_ADD, 16'hAAAA);
    send_cmd(OP_ADD, 16'h5555);
    for (i = 1; i <= 6; i++) send_cmd(OP_ADD, i[KEY_W-1:0]);
    send_cmd(OP_ADD, 16'h7777);
    // duplicate wins over full
    send_cmd(OP_ADD, 16'h0001);
    send_cmd(OP_REMOVE, 16'h0000);
    send_cmd(OP_REMOVE, 16'h0006);
    send_cmd(OP_REMOVE, 16'h0003);
    send_cmd(OP_QUERY, 16'h0004);
    send_cmd(OP_ADD, 16'h8000);
    wait_drain();
  endtask

  task automatic test_random(int n, int add_pct, int idle_pct, int rx_stall_pct);
    logic [KEY_W-1:0] pool [14];
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
    int               r;
    int               i;
    sender_idle_pct = idle_pct;
    stall_pct = rx_stall_pct;
    for (i = 0; i < 14; i++) pool[i] = KEY_W'($urandom_range(16'hFFFF));
    for (i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < add_pct) op = OP_ADD;
      else if (r < add_pct + 30) op = OP_REMOVE;
      else if (r < 95) op = OP_QUERY;
      else op = OP_UNUSED;
      r = $urandom_range(99);
      if (op != OP_ADD && key_total > 0 && r < 60) begin
        key = key_table[$urandom_range(key_total - 1)];
      end else if (r < 88) begin
        key = pool[$urandom_range(13)];
      end else begin
        key = KEY_W'($urandom_range(16'hFFFF));
      end
      send_cmd(op, key);
    end
    wait_drain();
  endtask

  // hold the result side off so the block fills and stalls its input
  task automatic test_backpressure();
    int i;
    sender_idle_pct = 0;
    stall_pct = 0;
    @(posedge clk);
    hold_req = 1'b1;
    for (i = 0; i < 40; i++) begin
      send_cmd(($urandom_range(1) != 0) ? OP_ADD : OP_QUERY, KEY_W'($urandom_range(15)));
    end
    wait_drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random(440, 40, 0, 0);
    test_random(440, 25, 65, 0);
    test_random(440, 50, 0, 65);
    test_random(440, 35, 6, 6);
    repeat (20) @(posedge clk);
    if (err_cnt == 0 && result_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
